@@ design/sta_pkg.sv @@
package sta_pkg;

  localparam int unsigned MaxSensorsDef = 16;
  localparam int unsigned AvgLengthDef  = 8;

  localparam int unsigned IdW    = 16;
  localparam int unsigned RoomW  = 16;
  localparam int unsigned ValueW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 5;

  localparam logic OpMap    = 1'b0;
  localparam logic OpSample = 1'b1;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StUnknown = 2'd1,
    StFull    = 2'd2,
    StEnd     = 2'd3
  } status_e;

  typedef struct packed {
    logic                     opcode;
    logic [IdW-1:0]           probe_id;
    logic [RoomW-1:0]         room_id;
    logic signed [ValueW-1:0] sample_value;
    logic [TimeW-1:0]         timestamp;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic [RoomW-1:0]         room_of_sensor;
    logic signed [ValueW-1:0] average_value;
    logic [TimeW-1:0]         last_time;
    logic [CountW-1:0]        sensor_count;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic finish;
  } mean_ctl_t;

endpackage

@@ design/sta_mean.sv @@
module sta_mean #(
  parameter int unsigned AVG_LENGTH = sta_pkg::AvgLengthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sta_pkg::mean_ctl_t                ctl_i,
  input  logic signed [sta_pkg::ValueW-1:0] sample_i,
  output logic                              done_o,
  output logic signed [sta_pkg::ValueW-1:0] avg_o
);
  import sta_pkg::*;

  localparam int unsigned LenLog = $clog2(AVG_LENGTH);
  localparam int unsigned SumW   = ValueW + LenLog;
  localparam int unsigned ShiftK = SumW + LenLog;
  localparam int unsigned MultW  = SumW + 2;
  localparam int unsigned ProdW  = SumW + MultW;
  localparam longint unsigned PowK = 64'd1 << ShiftK;
  localparam longint unsigned Mult = (PowK + AVG_LENGTH - 1) / AVG_LENGTH;
  localparam longint unsigned Bias = 64'd32768 * AVG_LENGTH;

  logic signed [SumW-1:0] acc_q, acc_d;
  logic [SumW-1:0]        biased;
  logic [ProdW-1:0]       prod_q;
  logic                   done_q;
  logic [ValueW-1:0]      quot;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (ctl_i.add) begin
      acc_d = acc_q + SumW'(sample_i);
    end
  end

  assign biased = SumW'(acc_q) + SumW'(Bias);

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctl_i.finish) begin
      prod_q <= ProdW'(biased) * ProdW'(MultW'(Mult));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.finish;
    end
  end

  // remove the bias of one half range
  assign quot   = prod_q[ShiftK +: ValueW];
  assign avg_o  = {~quot[ValueW-1], quot[ValueW-2:0]};
  assign done_o = done_q;

endmodule

@@ design/sensor_table_running_average.sv @@
// A map item writes its entry and clears its ring; a full table goes straight to the result.
// A sample item scans the entries up to the match, updates it and sums its ring for the mean;
// an unknown sensor scans every loaded entry, an end marker goes straight to the result.
// One item is in work at a time; the input stalls until its result is registered.
// Reset clears the sensor count, the state and the flags; both memories hold no reset value.
module sensor_table_running_average #(
  parameter int unsigned MAX_SENSORS = sta_pkg::MaxSensorsDef,
  parameter int unsigned AVG_LENGTH  = sta_pkg::AvgLengthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sta_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sta_pkg::out_item_t out_item_o
);
  import sta_pkg::*;

  localparam int unsigned CntW      = $clog2(MAX_SENSORS + 1);
  localparam int unsigned IdxW      = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int unsigned PtrW      = $clog2(AVG_LENGTH);
  localparam int unsigned SlotCntW  = $clog2(AVG_LENGTH + 1);
  localparam int unsigned RingDepth = MAX_SENSORS * AVG_LENGTH;
  localparam int unsigned RingAw    = $clog2(RingDepth);

  localparam logic [2:0] SIdle     = 3'd0;
  localparam logic [2:0] SDispatch = 3'd1;
  localparam logic [2:0] SScan     = 3'd2;
  localparam logic [2:0] SUpdate   = 3'd3;
  localparam logic [2:0] SClear    = 3'd4;
  localparam logic [2:0] SSum      = 3'd5;
  localparam logic [2:0] SMean     = 3'd6;
  localparam logic [2:0] SResult   = 3'd7;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [RoomW-1:0] room;
    logic [TimeW-1:0] ts;
    logic [PtrW-1:0]  ptr;
  } entry_t;

  logic [2:0]            state_q, state_d;
  in_item_t              item_q;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       scan_q, scan_d;
  logic                  pend_q, pend_d;
  logic [IdxW-1:0]       pend_idx_q;
  logic [IdxW-1:0]       idx_q, idx_d;
  entry_t                ent_q, ent_d;
  logic [SlotCntW-1:0]   slot_q, slot_d;
  logic                  rpend_q, rpend_d;
  out_item_t             res_q, res_d;
  out_item_t             out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  entry_t                entry_mem [MAX_SENSORS];
  entry_t                ent_rdata_q;
  logic                  ent_re, ent_we;
  logic [IdxW-1:0]       ent_waddr;
  entry_t                ent_wdata;

  logic signed [ValueW-1:0] ring_mem [RingDepth];
  logic signed [ValueW-1:0] ring_rdata_q;
  logic                     ring_re, ring_we;
  logic [RingAw-1:0]        ring_raddr, ring_waddr, ring_base;
  logic signed [ValueW-1:0] ring_wdata;

  logic                     accept;
  logic                     issue;
  logic                     hit;
  logic [PtrW-1:0]          ptr_next;
  mean_ctl_t                mean_ctl;
  logic                     mean_done;
  logic signed [ValueW-1:0] mean_avg;

  assign accept   = in_valid_i && !in_stall_o;
  assign hit      = pend_q && (ent_rdata_q.id == item_q.probe_id);
  assign ptr_next = (ent_q.ptr == PtrW'(AVG_LENGTH - 1)) ? '0 : ent_q.ptr + PtrW'(1);
  assign ring_base = RingAw'(idx_q) * RingAw'(AVG_LENGTH);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    idx_d       = idx_q;
    ent_d       = ent_q;
    slot_d      = slot_q;
    rpend_d     = 1'b0;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    issue       = 1'b0;
    ent_re      = 1'b0;
    ent_we      = 1'b0;
    ent_waddr   = idx_q;
    ent_wdata   = ent_q;
    ring_re     = 1'b0;
    ring_we     = 1'b0;
    ring_raddr  = ring_base + RingAw'(slot_q[PtrW-1:0]);
    ring_waddr  = ring_base + RingAw'(slot_q[PtrW-1:0]);
    ring_wdata  = '0;
    mean_ctl    = '0;

    case (state_q)
      SIdle: begin
        if (accept) begin
          state_d = SDispatch;
        end
      end
      SDispatch: begin
        res_d = '0;
        if (item_q.opcode == OpMap) begin
          if (count_q == CntW'(MAX_SENSORS)) begin
            res_d.status = StFull;
            state_d      = SResult;
          end else begin
            ent_we         = 1'b1;
            ent_waddr      = count_q[IdxW-1:0];
            ent_wdata.id   = item_q.probe_id;
            ent_wdata.room = item_q.room_id;
            ent_wdata.ts   = '0;
            ent_wdata.ptr  = '0;
            idx_d          = count_q[IdxW-1:0];
            count_d        = count_q + CntW'(1);
            slot_d         = '0;
            res_d.status         = StOk;
            res_d.room_of_sensor = item_q.room_id;
            state_d        = SClear;
          end
        end else if (item_q.probe_id == '0) begin
          res_d.status = StEnd;
          state_d      = SResult;
        end else begin
          scan_d  = '0;
          state_d = SScan;
        end
      end
      SScan: begin
        issue  = (scan_q < count_q) && !hit;
        ent_re = issue;
        pend_d = issue;
        if (issue) begin
          scan_d = scan_q + CntW'(1);
        end
        if (hit) begin
          ent_d   = ent_rdata_q;
          idx_d   = pend_idx_q;
          state_d = SUpdate;
        end else if (!pend_q && !issue) begin
          res_d.status = StUnknown;
          state_d      = SResult;
        end
      end
      SUpdate: begin
        ent_we        = 1'b1;
        ent_wdata.ts  = item_q.timestamp;
        ent_wdata.ptr = ptr_next;
        ring_we       = 1'b1;
        ring_waddr    = ring_base + RingAw'(ptr_next);
        ring_wdata    = item_q.sample_value;
        mean_ctl.clear = 1'b1;
        slot_d        = '0;
        res_d.status         = StOk;
        res_d.room_of_sensor = ent_q.room;
        res_d.last_time      = item_q.timestamp;
        state_d       = SSum;
      end
      SClear: begin
        ring_we = 1'b1;
        slot_d  = slot_q + SlotCntW'(1);
        if (slot_q[PtrW-1:0] == PtrW'(AVG_LENGTH - 1)) begin
          state_d = SResult;
        end
      end
      SSum: begin
        issue   = slot_q < SlotCntW'(AVG_LENGTH);
        ring_re = issue;
        rpend_d = issue;
        mean_ctl.add = rpend_q;
        if (issue) begin
          slot_d = slot_q + SlotCntW'(1);
        end else if (!rpend_q) begin
          mean_ctl.finish = 1'b1;
          state_d         = SMean;
        end
      end
      SMean: begin
        if (mean_done) begin
          res_d.average_value = mean_avg;
          state_d             = SResult;
        end
      end
      SResult: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d              = res_q;
          out_d.sensor_count = CountW'(count_q);
          out_valid_d        = 1'b1;
          state_d            = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      entry_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rdata_q <= entry_mem[scan_q[IdxW-1:0]];
    end
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    if (ring_re) begin
      ring_rdata_q <= ring_mem[ring_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
    scan_q     <= scan_d;
    pend_idx_q <= scan_q[IdxW-1:0];
    idx_q      <= idx_d;
    ent_q      <= ent_d;
    slot_q     <= slot_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      pend_q      <= 1'b0;
      rpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      rpend_q     <= rpend_d;
      out_valid_q <= out_valid_d;
    end
  end

  sta_mean #(
    .AVG_LENGTH(AVG_LENGTH)
  ) u_mean (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mean_ctl),
    .sample_i(ring_rdata_q),
    .done_o  (mean_done),
    .avg_o   (mean_avg)
  );

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_SENSORS))
    else $error("sensor count beyond table size");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CntW'(1)))
    else $error("sensor count moved by other than one");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input taken while an item is in work");

  a_mean_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mean_done |-> (state_q == SMean))
    else $error("mean result outside the mean wait");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_re |-> (scan_q < count_q))
    else $error("entry read beyond loaded sensors");

endmodule

@@ dv/testbench.sv @@
module testbench;
  import sta_pkg::*;

  localparam int unsigned CycleLimit = 500_000;
  localparam int unsigned DrainCycles = 40;

  class avg_table_scoreboard;
    logic [IdW-1:0]           ids   [MaxSensorsDef];
    logic [RoomW-1:0]         rooms [MaxSensorsDef];
    logic [TimeW-1:0]         times [MaxSensorsDef];
    int                       ptrs  [MaxSensorsDef];
    logic signed [ValueW-1:0] ring  [MaxSensorsDef][AvgLengthDef];
    int                       total;
    out_item_t                expected_q[$];
    int                       errors;

    function new();
      total  = 0;
      errors = 0;
    endfunction

    function void note_transfer(in_item_t item);
      out_item_t res;
      int        hit;
      int        sum;
      int        mean;
      res = '0;
      hit = -1;
      if (item.opcode == OpMap) begin
        if (total >= MaxSensorsDef) begin
          res.status = StFull;
        end else begin
          ids[total]   = item.probe_id;
          rooms[total] = item.room_id;
          times[total] = '0;
          ptrs[total]  = 0;
          for (int s = 0; s < AvgLengthDef; s++) ring[total][s] = '0;
          total++;
          res.status         = StOk;
          res.room_of_sensor = item.room_id;
        end
      end else if (item.probe_id == '0) begin
        res.status = StEnd;
      end else begin
        for (int e = 0; e < total; e++) begin
          if (hit < 0 && ids[e] == item.probe_id) hit = e;
        end
        if (hit < 0) begin
          res.status = StUnknown;
        end else begin
          times[hit] = item.timestamp;
          ptrs[hit]  = (ptrs[hit] == AvgLengthDef - 1) ? 0 : ptrs[hit] + 1;
          ring[hit][ptrs[hit]] = item.sample_value;
          sum = 0;
          for (int s = 0; s < AvgLengthDef; s++) sum += int'(ring[hit][s]);
          mean = (sum >= 0) ? sum / int'(AvgLengthDef)
                            : -((-sum + int'(AvgLengthDef) - 1) / int'(AvgLengthDef));
          res.status         = StOk;
          res.room_of_sensor = rooms[hit];
          res.average_value  = mean[ValueW-1:0];
          res.last_time      = times[hit];
        end
      end
      res.sensor_count = total[CountW-1:0];
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing pending: %p", got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        compare_field("status", longint'(exp_r.status), longint'(got.status));
        compare_field("room_of_sensor", longint'(exp_r.room_of_sensor),
                      longint'(got.room_of_sensor));
        compare_field("average_value", longint'($signed(exp_r.average_value)),
                      longint'($signed(got.average_value)));
        compare_field("last_time", longint'(exp_r.last_time), longint'(got.last_time));
        compare_field("sensor_count", longint'(exp_r.sensor_count),
                      longint'(got.sensor_count));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  avg_table_scoreboard sb = new();

  int              cycles     = 0;
  int              sent       = 0;
  int              burst_left = 0;
  logic [IdW-1:0]  known_ids[$];

  sensor_table_running_average i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #2 clk = ~clk;

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  function automatic in_item_t make_item(logic op, logic [IdW-1:0] id,
                                         logic [RoomW-1:0] room,
                                         logic signed [ValueW-1:0] value,
                                         logic [TimeW-1:0] stamp);
    in_item_t item;
    item.opcode       = op;
    item.probe_id     = id;
    item.room_id      = room;
    item.sample_value = value;
    item.timestamp    = stamp;
    return item;
  endfunction

  function automatic logic signed [ValueW-1:0] rand_value();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return ValueW'($urandom());
    endcase
  endfunction

  // enter and leave on a falling edge
  task automatic offer(in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_transfer(item);
    sent++;
    burst_left--;
    @(negedge clk);
  endtask

  initial begin
    int mode;
    int len;
    int next_hold;
    next_hold = 80;
    @(posedge rst_n);
    forever begin
      if (sent >= next_hold) begin
        next_hold = (next_hold < 400) ? 450 : 1 << 30;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
      end else begin
        mode = $urandom_range(9);
        len  = $urandom_range(5, 60);
        repeat (len) begin
          case (mode)
            0, 1, 2, 3: out_stall <= 1'b0;
            4, 5, 6, 7: out_stall <= ($urandom_range(3) == 0);
            8:          out_stall <= 1'($urandom_range(1));
            default:    out_stall <= 1'b1;
          endcase
          @(negedge clk);
        end
      end
    end
  end

  initial begin
    logic [IdW-1:0] id;
    int             r;
    @(posedge rst_n);
    @(negedge clk);

    offer(make_item(OpSample, 16'd5, 16'hFFFF, 16'sh7FFF, 32'hFFFF_FFFF));
    offer(make_item(OpSample, 16'h0000, 16'hFFFF, 16'sh8000, 32'hFFFF_FFFF));
    offer(make_item(OpMap, 16'h0000, 16'h0000, 16'sh0000, 32'h0000_0000));
    offer(make_item(OpMap, 16'hFFFF, 16'hFFFF, 16'sh8000, 32'hFFFF_FFFF));
    offer(make_item(OpMap, 16'h1234, 16'h00AA, 16'sh7FFF, 32'h0000_0001));
    offer(make_item(OpMap, 16'h1234, 16'h5555, 16'sh0001, 32'h0000_0002));
    offer(make_item(OpSample, 16'h0000, 16'h0000, 16'sh1234, 32'h0000_0003));
    for (int k = 0; k < 9; k++) begin
      offer(make_item(OpSample, 16'hFFFF, 16'h0000, 16'sh8000, 32'hFFFF_FFFF - k));
    end
    for (int k = 0; k < 8; k++) begin
      offer(make_item(OpSample, 16'h1234, 16'hFFFF, 16'sh7FFF, k));
    end
    offer(make_item(OpSample, 16'h7777, 16'h0000, 16'sh0000, 32'h0000_0000));
    known_ids = '{16'h0000, 16'hFFFF, 16'h1234, 16'h1234};

    repeat (675) begin
      r = $urandom_range(99);
      if (r < 8) begin
        case ($urandom_range(9))
          0:       id = '0;
          1, 2:    id = known_ids[$urandom_range(known_ids.size() - 1)];
          default: id = IdW'($urandom());
        endcase
        if (known_ids.size() < MaxSensorsDef) known_ids.push_back(id);
        offer(make_item(OpMap, id, RoomW'($urandom()), rand_value(), $urandom()));
      end else if (r < 80) begin
        id = known_ids[$urandom_range(known_ids.size() - 1)];
        offer(make_item(OpSample, id, RoomW'($urandom()), rand_value(), $urandom()));
      end else if (r < 93) begin
        offer(make_item(OpSample, IdW'($urandom()), RoomW'($urandom()), rand_value(),
                        $urandom()));
      end else begin
        offer(make_item(OpSample, '0, RoomW'($urandom()), rand_value(), $urandom()));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
